>>> rtl/csc_pkg.sv
`timescale 1ns / 1ps
package csc_pkg;

  localparam int NUM_CELLS    = 262144;
  localparam int NUM_CLUSTERS = 1024;
  localparam int CL_W         = 10;
  localparam int IDX_W        = 18;
  localparam int CNT_W        = 19;
  localparam int SHR_W        = 20;
  localparam int Q_DEPTH      = 2;
  localparam int Q_AW         = $clog2(Q_DEPTH);
  localparam int DIV_STEPS    = 48;

  // request codes
  localparam logic [2:0] REQ_CELL   = 3'd0;
  localparam logic [2:0] REQ_RD_ALL = 3'd1;
  localparam logic [2:0] REQ_RD_IN  = 3'd2;
  localparam logic [2:0] REQ_RD_CL  = 3'd3;
  localparam logic [2:0] REQ_CLR    = 3'd4;

  // count slots, slot zero is the total
  localparam logic [2:0] CLS_TOTAL = 3'd0;
  localparam logic [2:0] CLS_SEED  = 3'd1;
  localparam logic [2:0] CLS_GROW  = 3'd2;
  localparam logic [2:0] CLS_TERM  = 3'd3;
  localparam logic [2:0] CLS_BELOW = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SEED = 2'd0;
  localparam logic [1:0] CFG_GROW = 2'd1;
  localparam logic [1:0] CFG_CELL = 2'd2;

  typedef logic [4:0][CNT_W-1:0] cnt_arr_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       cls;
    logic [31:0]      snr;
    logic [31:0]      mag;
    logic [IDX_W-1:0] idx;
    logic             inc;
    logic             shared;
    logic [CL_W-1:0]  prim;
    logic [CL_W-1:0]  sec;
    logic [CL_W-1:0]  rdc;
  } op_t;

  typedef struct packed {
    cnt_arr_t         cnt;
    logic [SHR_W-1:0] shr;
    logic [31:0]      max_snr;
    logic [31:0]      max_energy;
    logic [IDX_W-1:0] max_cell;
    logic             has_max;
  } res_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  function automatic logic [CNT_W-1:0] sat19(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [SHR_W-1:0] sat20(input logic [SHR_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic cl_ok(input logic [CL_W-1:0] c);
    return 32'(c) < NUM_CLUSTERS;
  endfunction

endpackage

>>> rtl/csc_queue.sv
`timescale 1ns / 1ps
module csc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  csc_pkg::op_t  push_data,
  output logic          q_full,
  input  logic          pop,
  output logic          q_empty,
  output csc_pkg::op_t  head
);
  import csc_pkg::*;

  op_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;

  assign q_full  = (32'(cnt_r) == Q_DEPTH);
  assign q_empty = (cnt_r == '0);
  assign head    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule

>>> rtl/csc_front.sv
`timescale 1ns / 1ps
module csc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [2:0]                 in_req_type,
  input  logic [csc_pkg::IDX_W-1:0]  in_cell_index,
  input  logic signed [31:0]         in_energy,
  input  logic [31:0]                in_noise,
  input  logic                       in_in_cluster,
  input  logic                       in_is_shared,
  input  logic [csc_pkg::CL_W-1:0]   in_primary_cluster,
  input  logic [csc_pkg::CL_W-1:0]   in_secondary_cluster,
  input  logic [csc_pkg::CL_W-1:0]   in_read_cluster,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  csc_pkg::back_stat_t        bstat,
  input  logic                       q_full,
  output logic                       q_push,
  output csc_pkg::op_t               q_data
);
  import csc_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fst_t;

  fst_t        st_r, st_nxt;
  op_t         op_r, op_nxt;
  logic [31:0] noise_r, noise_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [47:0] dq_r, dq_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] seed_thr_r, grow_thr_r, cell_thr_r;
  logic [31:0] mag;
  logic [32:0] shifted;
  logic [33:0] sub;
  logic        ge;
  logic [47:0] step_dq;
  logic        accept;

  assign full   = (st_r != F_IDLE) || bstat.init_busy;
  assign accept = push && !full;
  assign mag    = in_energy[31] ? (~in_energy + 32'd1) : in_energy;

  // one restoring division step per cycle
  assign shifted = {rem_r, dq_r[47]};
  assign sub     = {1'b0, shifted} - {2'b0, noise_r};
  assign ge      = ~sub[33];
  assign step_dq = {dq_r[46:0], ge};

  always_comb begin
    q_data = op_r;
    if (op_r.snr > seed_thr_r)      q_data.cls = CLS_SEED;
    else if (op_r.snr > grow_thr_r) q_data.cls = CLS_GROW;
    else if (op_r.snr > cell_thr_r) q_data.cls = CLS_TERM;
    else                            q_data.cls = CLS_BELOW;
  end

  always_comb begin
    st_nxt    = st_r;
    op_nxt    = op_r;
    noise_nxt = noise_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    cnt_nxt   = cnt_r;
    q_push    = 1'b0;
    case (st_r)
      F_IDLE: begin
        if (accept) begin
          op_nxt.kind   = in_req_type;
          op_nxt.cls    = CLS_BELOW;
          op_nxt.snr    = 32'hFFFF_FFFF;
          op_nxt.mag    = mag;
          op_nxt.idx    = in_cell_index;
          op_nxt.inc    = in_in_cluster;
          op_nxt.shared = in_is_shared;
          op_nxt.prim   = in_primary_cluster;
          op_nxt.sec    = in_is_shared ? in_secondary_cluster : in_primary_cluster;
          op_nxt.rdc    = in_read_cluster;
          noise_nxt     = in_noise;
          rem_nxt       = '0;
          dq_nxt        = {mag, 16'd0};
          cnt_nxt       = 6'(DIV_STEPS - 1);
          case (in_req_type)
            REQ_CELL: begin
              if (32'(in_cell_index) < NUM_CELLS) begin
                st_nxt = (in_noise == '0) ? F_PUSH : F_DIV;
              end
            end
            REQ_RD_ALL, REQ_RD_IN, REQ_RD_CL, REQ_CLR: st_nxt = F_PUSH;
            default: st_nxt = F_IDLE;
          endcase
        end
      end
      F_DIV: begin
        rem_nxt = ge ? sub[31:0] : shifted[31:0];
        dq_nxt  = step_dq;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          op_nxt.snr = (step_dq[47:32] != '0) ? 32'hFFFF_FFFF : step_dq[31:0];
          st_nxt     = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    noise_r <= noise_nxt;
    rem_r   <= rem_nxt;
    dq_r    <= dq_nxt;
    cnt_r   <= cnt_nxt;
    if (!rst_n) begin
      st_r       <= F_IDLE;
      seed_thr_r <= 32'h0004_0000;
      grow_thr_r <= 32'h0002_0000;
      cell_thr_r <= 32'h0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEED: seed_thr_r <= cfg_data;
          CFG_GROW: grow_thr_r <= cfg_data;
          CFG_CELL: cell_thr_r <= cfg_data;
          default:  ;
        endcase
      end
    end
  end
endmodule

>>> rtl/csc_back.sv
`timescale 1ns / 1ps
module csc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  csc_pkg::op_t         head,
  output logic                 q_pop,
  output csc_pkg::back_stat_t  bstat,
  output logic                 res_valid,
  output csc_pkg::res_t        res,
  input  logic                 res_pop
);
  import csc_pkg::*;

  typedef enum logic [2:0] {B_INIT, B_IDLE, B_PWAIT, B_SRD, B_SWAIT, B_CWAIT} bst_t;

  typedef struct packed {
    logic             live;
    cnt_arr_t         cnt;
    logic [SHR_W-1:0] shr;
    logic             bval;
    logic [31:0]      bsnr;
    logic [31:0]      beng;
    logic [IDX_W-1:0] bcell;
  } entry_t;

  entry_t mem [NUM_CLUSTERS];
  entry_t rdata_r, cur, wd;
  logic [CL_W-1:0] rd_addr, wa, clr_r, clr_nxt;
  logic            we;

  bst_t             st_r, st_nxt;
  op_t              op_r, op_nxt;
  cnt_arr_t         all_r, all_nxt, inc_r, inc_nxt;
  logic [SHR_W-1:0] ishr_r, ishr_nxt;
  logic             rv_r, rv_nxt;
  res_t             res_r, res_nxt;
  logic             slot_free;

  assign bstat.init_busy = (st_r == B_INIT);
  assign res_valid       = rv_r;
  assign res             = res_r;
  assign slot_free       = !rv_r || res_pop;

  // entry seen as live; a dead entry reads as zero
  always_comb begin
    cur = rdata_r;
    if (!rdata_r.live) cur = '0;
    cur.live = 1'b1;
  end

  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    all_nxt  = all_r;
    inc_nxt  = inc_r;
    ishr_nxt = ishr_r;
    rv_nxt   = rv_r && !res_pop;
    res_nxt  = res_r;
    clr_nxt  = clr_r;
    q_pop    = 1'b0;
    rd_addr  = op_r.sec;
    we       = 1'b0;
    wa       = op_r.prim;
    wd       = cur;
    case (st_r)
      B_INIT: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = '0;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == NUM_CLUSTERS - 1) st_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          op_nxt = head;
          case (head.kind)
            REQ_CELL: begin
              q_pop = 1'b1;
              all_nxt[CLS_TOTAL] = sat19(all_r[CLS_TOTAL]);
              all_nxt[head.cls]  = sat19(all_r[head.cls]);
              if (head.inc) begin
                inc_nxt[CLS_TOTAL] = sat19(inc_r[CLS_TOTAL]);
                inc_nxt[head.cls]  = sat19(inc_r[head.cls]);
                if (head.shared) ishr_nxt = sat20(ishr_r);
                if (cl_ok(head.prim)) begin
                  rd_addr = head.prim;
                  st_nxt  = B_PWAIT;
                end else if (head.shared && cl_ok(head.sec)) begin
                  rd_addr = head.sec;
                  st_nxt  = B_SWAIT;
                end
              end
            end
            REQ_RD_ALL, REQ_RD_IN: begin
              if (slot_free) begin
                q_pop   = 1'b1;
                rv_nxt  = 1'b1;
                res_nxt = '0;
                if (head.kind == REQ_RD_ALL) begin
                  res_nxt.cnt = all_r;
                end else begin
                  res_nxt.cnt = inc_r;
                  res_nxt.shr = ishr_r;
                end
              end
            end
            REQ_RD_CL: begin
              if (slot_free) begin
                q_pop   = 1'b1;
                rd_addr = head.rdc;
                st_nxt  = B_CWAIT;
              end
            end
            REQ_CLR: begin
              q_pop    = 1'b1;
              all_nxt  = '0;
              inc_nxt  = '0;
              ishr_nxt = '0;
              clr_nxt  = '0;
              st_nxt   = B_INIT;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      B_PWAIT: begin
        we = 1'b1;
        wa = op_r.prim;
        wd = cur;
        if (!op_r.shared &&
            (!cur.bval || op_r.snr > cur.bsnr ||
             (op_r.snr == cur.bsnr && op_r.idx > cur.bcell))) begin
          wd.bval  = 1'b1;
          wd.bsnr  = op_r.snr;
          wd.beng  = op_r.mag;
          wd.bcell = op_r.idx;
        end
        wd.cnt[CLS_TOTAL] = sat19(cur.cnt[CLS_TOTAL]);
        wd.cnt[op_r.cls]  = sat19(cur.cnt[op_r.cls]);
        if (op_r.shared) wd.shr = sat20(cur.shr);
        st_nxt = (op_r.shared && cl_ok(op_r.sec)) ? B_SRD : B_IDLE;
      end
      B_SRD: begin
        rd_addr = op_r.sec;
        st_nxt  = B_SWAIT;
      end
      B_SWAIT: begin
        we = 1'b1;
        wa = op_r.sec;
        wd = cur;
        if (op_r.sec != op_r.prim) begin
          wd.cnt[CLS_TOTAL] = sat19(cur.cnt[CLS_TOTAL]);
          wd.cnt[op_r.cls]  = sat19(cur.cnt[op_r.cls]);
        end
        wd.shr = sat20(cur.shr);
        st_nxt = B_IDLE;
      end
      B_CWAIT: begin
        rv_nxt  = 1'b1;
        res_nxt = '0;
        if (cl_ok(op_r.rdc) && rdata_r.live) begin
          res_nxt.cnt = rdata_r.cnt;
          res_nxt.shr = rdata_r.shr;
          if (rdata_r.bval) begin
            res_nxt.max_snr    = rdata_r.bsnr;
            res_nxt.max_energy = rdata_r.beng;
            res_nxt.max_cell   = rdata_r.bcell;
            res_nxt.has_max    = 1'b1;
          end
        end
        st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    res_r <= res_nxt;
    if (!rst_n) begin
      st_r   <= B_INIT;
      clr_r  <= '0;
      all_r  <= '0;
      inc_r  <= '0;
      ishr_r <= '0;
      rv_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      all_r  <= all_nxt;
      inc_r  <= inc_nxt;
      ishr_r <= ishr_nxt;
      rv_r   <= rv_nxt;
    end
  end
endmodule

>>> rtl/cell_snr_cluster_counter_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake            transfer when
// in_*      input      push / full          push && !full
// out_*     output     empty / pop          pop && !empty
// cfg_*     input      cfg_we               cfg_we (no wait, no read-back)
//
// a cell passes latch, division and push in the front, which takes no new item until
// the push is done; the restoring divider in the front makes one quotient bit per cycle
// the back handles one item at a time (up to two read-modify-writes of the cluster
// memory for a shared cell); the two-entry queue lets it overlap the next division
// after reset, and after each clear request, the back sweeps all 1024 cluster
// entries, one per cycle; full stays high during the sweep
// a waiting result holds the back at the next read request; the queue then fills
// and full rises
module cell_snr_cluster_counter_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [2:0]                 in_req_type,
  input  logic [csc_pkg::IDX_W-1:0]  in_cell_index,
  input  logic signed [31:0]         in_energy,
  input  logic [31:0]                in_noise,
  input  logic                       in_in_cluster,
  input  logic                       in_is_shared,
  input  logic [csc_pkg::CL_W-1:0]   in_primary_cluster,
  input  logic [csc_pkg::CL_W-1:0]   in_secondary_cluster,
  input  logic [csc_pkg::CL_W-1:0]   in_read_cluster,
  output logic                       empty,
  input  logic                       pop,
  output logic [csc_pkg::CNT_W-1:0]  out_total_count,
  output logic [csc_pkg::CNT_W-1:0]  out_seed_count,
  output logic [csc_pkg::CNT_W-1:0]  out_grow_count,
  output logic [csc_pkg::CNT_W-1:0]  out_term_count,
  output logic [csc_pkg::CNT_W-1:0]  out_below_count,
  output logic [csc_pkg::SHR_W-1:0]  out_shared_count,
  output logic [31:0]                out_max_snr,
  output logic [31:0]                out_max_energy,
  output logic [csc_pkg::IDX_W-1:0]  out_max_cell,
  output logic                       out_has_max,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);
  import csc_pkg::*;

  logic       q_push, q_pop, q_full, q_empty;
  op_t        q_data, q_head;
  back_stat_t bstat;
  logic       res_valid;
  res_t       res;

  // front: latch, divide, classify
  csc_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_req_type(in_req_type), .in_cell_index(in_cell_index),
    .in_energy(in_energy), .in_noise(in_noise), .in_in_cluster(in_in_cluster),
    .in_is_shared(in_is_shared), .in_primary_cluster(in_primary_cluster),
    .in_secondary_cluster(in_secondary_cluster), .in_read_cluster(in_read_cluster),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .bstat(bstat), .q_full(q_full), .q_push(q_push), .q_data(q_data)
  );

  // decoupling queue of classified operations
  csc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data), .q_full(q_full),
    .pop(q_pop), .q_empty(q_empty), .head(q_head)
  );

  // back: counters, cluster memory, result register
  csc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .head(q_head), .q_pop(q_pop),
    .bstat(bstat), .res_valid(res_valid), .res(res), .res_pop(pop)
  );

  assign empty            = !res_valid;
  assign out_total_count  = res.cnt[CLS_TOTAL];
  assign out_seed_count   = res.cnt[CLS_SEED];
  assign out_grow_count   = res.cnt[CLS_GROW];
  assign out_term_count   = res.cnt[CLS_TERM];
  assign out_below_count  = res.cnt[CLS_BELOW];
  assign out_shared_count = res.shr;
  assign out_max_snr      = res.max_snr;
  assign out_max_energy   = res.max_energy;
  assign out_max_cell     = res.max_cell;
  assign out_has_max      = res.has_max;

  // no item enters while the cluster memory is being swept after reset or a clear
  a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.init_busy |-> full) else $error("item accepted during sweep");

  // the decoupling queue never takes an item while full
  a_q_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("operation queue overflow");

  // a result without a best cell carries zero best SNR and best cell index
  a_no_max_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_has_max) |-> (out_max_snr == '0 && out_max_cell == '0))
    else $error("best-cell fields set without has_max");
endmodule

>>> test/cell_snr_cluster_counter_unit_tb.sv
`timescale 1ns / 1ps
module cell_snr_cluster_counter_unit_tb;
  import csc_pkg::*;

  // request codes the block must drop without a result
  localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
  localparam logic [2:0] REQ_BAD_LAST  = 3'd7;
  // a cell leaves no result, so after the last result the front may still be dividing
  localparam int CELL_LATENCY = 60;
  // covers the cluster sweep after a clear before any threshold write
  localparam int SWEEP_WAIT   = 1200;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [31:0] SNR_SAT = 32'hFFFF_FFFF;

  typedef struct {
    logic [2:0]        req;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       energy;
    logic [31:0]       noise;
    logic              inc;
    logic              shared;
    logic [CL_W-1:0]   prim;
    logic [CL_W-1:0]   sec;
    logic [CL_W-1:0]   rdc;
  } cell_req_t;

  typedef struct {
    logic [CNT_W-1:0]  cnt [5];
    logic [SHR_W-1:0]  shr;
    logic [31:0]       max_snr;
    logic [31:0]       max_energy;
    logic [IDX_W-1:0]  max_cell;
    logic              has_max;
  } count_rpt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [2:0] in_req_type = REQ_CELL;
  logic [IDX_W-1:0] in_cell_index = '0;
  logic signed [31:0] in_energy = '0;
  logic [31:0] in_noise = '0;
  logic in_in_cluster = 1'b0;
  logic in_is_shared = 1'b0;
  logic [CL_W-1:0] in_primary_cluster = '0;
  logic [CL_W-1:0] in_secondary_cluster = '0;
  logic [CL_W-1:0] in_read_cluster = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CNT_W-1:0] out_total_count, out_seed_count, out_grow_count;
  logic [CNT_W-1:0] out_term_count, out_below_count;
  logic [SHR_W-1:0] out_shared_count;
  logic [31:0] out_max_snr, out_max_energy;
  logic [IDX_W-1:0] out_max_cell;
  logic out_has_max;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SEED;
  logic [31:0] cfg_data = '0;

  cell_snr_cluster_counter_unit DUT (.*);

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: thresholds, global counts and the per-cluster table
  logic [31:0] thr_seed = 32'h0004_0000;
  logic [31:0] thr_grow = 32'h0002_0000;
  logic [31:0] thr_cell = 32'h0;
  logic [CNT_W-1:0] all_counts [5];
  logic [SHR_W-1:0] clu_counts [6];
  logic [CNT_W-1:0] cl_class [NUM_CLUSTERS][5];
  logic [SHR_W-1:0] cl_shared [NUM_CLUSTERS];
  logic [31:0] cl_best_snr [NUM_CLUSTERS];
  logic [31:0] cl_best_energy [NUM_CLUSTERS];
  logic [IDX_W-1:0] cl_best_cell [NUM_CLUSTERS];
  logic cl_best_ok [NUM_CLUSTERS];
  logic cl_live [NUM_CLUSTERS];

  count_rpt_t pending_reports [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_start = 0;

  function automatic logic [CNT_W-1:0] bump19(logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [SHR_W-1:0] bump20(logic [SHR_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // |energy| in 32 bits, the most negative energy gives 2^31
  function automatic logic [31:0] abs_energy(logic [31:0] e);
    return e[31] ? (~e + 1'b1) : e;
  endfunction

  function automatic logic [31:0] snr_q16(logic [31:0] e, logic [31:0] n);
    logic [63:0] q;
    if (n == 0) return SNR_SAT;
    q = {16'h0, abs_energy(e), 16'h0} / {32'h0, n};
    return (q > 64'hFFFF_FFFF) ? SNR_SAT : q[31:0];
  endfunction

  task automatic clear_counts();
    for (int k = 0; k < 5; k++) all_counts[k] = '0;
    for (int k = 0; k < 6; k++) clu_counts[k] = '0;
    for (int c = 0; c < NUM_CLUSTERS; c++) cl_live[c] = 1'b0;
  endtask

  task automatic open_entry(int c);
    if (!cl_live[c]) begin
      for (int k = 0; k < 5; k++) cl_class[c][k] = '0;
      cl_shared[c] = '0;
      cl_best_ok[c] = 1'b0;
      cl_live[c] = 1'b1;
    end
  endtask

  task automatic count_cell(cell_req_t r);
    logic [31:0] snr;
    logic [2:0] cls;
    int p, s;
    p = r.prim;
    s = r.sec;
    if (r.idx >= NUM_CELLS) return;
    snr = snr_q16(r.energy, r.noise);
    if (snr > thr_seed) cls = CLS_SEED;
    else if (snr > thr_grow) cls = CLS_GROW;
    else if (snr > thr_cell) cls = CLS_TERM;
    else cls = CLS_BELOW;
    all_counts[CLS_TOTAL] = bump19(all_counts[CLS_TOTAL]);
    all_counts[cls] = bump19(all_counts[cls]);
    if (!r.inc) return;
    clu_counts[CLS_TOTAL] = bump19(clu_counts[CLS_TOTAL]);
    clu_counts[cls] = bump19(clu_counts[cls]);
    if (r.shared) clu_counts[5] = bump20(clu_counts[5]);
    if (p < NUM_CLUSTERS) begin
      open_entry(p);
      // shared cells never compete for the best cell, ties go to the higher index
      if (!r.shared && (!cl_best_ok[p] || snr > cl_best_snr[p] ||
          (snr == cl_best_snr[p] && r.idx > cl_best_cell[p]))) begin
        cl_best_snr[p] = snr;
        cl_best_energy[p] = abs_energy(r.energy);
        cl_best_cell[p] = r.idx;
        cl_best_ok[p] = 1'b1;
      end
      cl_class[p][CLS_TOTAL] = bump19(cl_class[p][CLS_TOTAL]);
      cl_class[p][cls] = bump19(cl_class[p][cls]);
      if (r.shared) cl_shared[p] = bump20(cl_shared[p]);
    end
    if (r.shared && s < NUM_CLUSTERS) begin
      open_entry(s);
      // same cluster on both sides: classes once, shared count twice
      if (s != p) begin
        cl_class[s][CLS_TOTAL] = bump19(cl_class[s][CLS_TOTAL]);
        cl_class[s][cls] = bump19(cl_class[s][cls]);
      end
      cl_shared[s] = bump20(cl_shared[s]);
    end
  endtask

  task automatic predict_request(cell_req_t r);
    count_rpt_t x;
    int c;
    for (int k = 0; k < 5; k++) x.cnt[k] = '0;
    x.shr = '0;
    x.max_snr = '0;
    x.max_energy = '0;
    x.max_cell = '0;
    x.has_max = 1'b0;
    case (r.req)
      REQ_CELL: begin
        count_cell(r);
        return;
      end
      REQ_CLR: begin
        clear_counts();
        return;
      end
      REQ_RD_ALL: begin
        for (int k = 0; k < 5; k++) x.cnt[k] = all_counts[k];
      end
      REQ_RD_IN: begin
        for (int k = 0; k < 5; k++) x.cnt[k] = clu_counts[k];
        x.shr = clu_counts[5];
      end
      REQ_RD_CL: begin
        c = r.rdc;
        if (c < NUM_CLUSTERS && cl_live[c]) begin
          for (int k = 0; k < 5; k++) x.cnt[k] = cl_class[c][k];
          x.shr = cl_shared[c];
          if (cl_best_ok[c]) begin
            x.max_snr = cl_best_snr[c];
            x.max_energy = cl_best_energy[c];
            x.max_cell = cl_best_cell[c];
            x.has_max = 1'b1;
          end
        end
      end
      default: return;
    endcase
    pending_reports.insert(pending_reports.size(), x);
  endtask

  // one input transfer, push stays high so back-to-back items need no gap
  task automatic send_req(cell_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_req_type <= r.req;
    in_cell_index <= r.idx;
    in_energy <= r.energy;
    in_noise <= r.noise;
    in_in_cluster <= r.inc;
    in_is_shared <= r.shared;
    in_primary_cluster <= r.prim;
    in_secondary_cluster <= r.sec;
    in_read_cluster <= r.rdc;
    do @(posedge clk); while (full);
    predict_request(r);
  endtask

  function automatic cell_req_t mk_cell(logic [IDX_W-1:0] idx, logic [31:0] e, logic [31:0] n,
                                        logic inc, logic sh, logic [CL_W-1:0] p,
                                        logic [CL_W-1:0] s);
    cell_req_t r;
    r.req = REQ_CELL;
    r.idx = idx;
    r.energy = e;
    r.noise = n;
    r.inc = inc;
    r.shared = sh;
    r.prim = p;
    r.sec = s;
    r.rdc = CL_W'($urandom);
    return r;
  endfunction

  function automatic cell_req_t mk_read(logic [2:0] req, logic [CL_W-1:0] c);
    cell_req_t r;
    r = mk_cell(IDX_W'($urandom), $urandom, $urandom, 1'($urandom), 1'($urandom),
                CL_W'($urandom), CL_W'($urandom));
    r.req = req;
    r.rdc = c;
    return r;
  endfunction

  function automatic logic [CL_W-1:0] pick_cluster();
    return ($urandom_range(9) == 0) ? CL_W'($urandom) : CL_W'($urandom_range(15));
  endfunction

  // mostly well-formed cells in a few busy clusters, energy and noise from small
  // sets so that SNRs land on the thresholds and tie often
  function automatic cell_req_t random_req();
    cell_req_t r;
    logic [31:0] e, n;
    logic [CL_W-1:0] p, s;
    int pick;
    pick = $urandom_range(99);
    case ($urandom_range(5))
      0: e = $urandom;
      1: e = {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: e = $urandom_range(1) ? 32'($urandom_range(40)) : -32'($urandom_range(40));
    endcase
    case ($urandom_range(9))
      0: n = '0;
      1, 2: n = $urandom;
      default: n = $urandom_range(1, 12);
    endcase
    p = pick_cluster();
    s = ($urandom_range(4) == 0) ? p : pick_cluster();
    r = mk_cell(IDX_W'($urandom), e, n, $urandom_range(99) < 85, $urandom_range(3) == 0,
                p, s);
    if (pick >= 97) r.req = 3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST));
    else if (pick >= 96) r.req = REQ_CLR;
    else if (pick >= 90) r = mk_read(REQ_RD_ALL, '0);
    else if (pick >= 84) r = mk_read(REQ_RD_IN, '0);
    else if (pick >= 72) r = mk_read(REQ_RD_CL, pick_cluster());
    return r;
  endfunction

  // stop sending, wait for every report, then let the divider run dry
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (CELL_LATENCY) @(posedge clk);
  endtask

  task automatic write_thresholds(logic [31:0] sd, logic [31:0] gr, logic [31:0] cl);
    drain();
    repeat (SWEEP_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SEED;
    cfg_data <= sd;
    @(posedge clk);
    cfg_index <= CFG_GROW;
    cfg_data <= gr;
    @(posedge clk);
    cfg_index <= CFG_CELL;
    cfg_data <= cl;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_seed = sd;
    thr_grow = gr;
    thr_cell = cl;
    @(posedge clk);
  endtask

  task automatic read_everything(logic [CL_W-1:0] c);
    send_req(mk_read(REQ_RD_ALL, '0));
    send_req(mk_read(REQ_RD_IN, '0));
    send_req(mk_read(REQ_RD_CL, c));
  endtask

  // extremes of energy and noise, saturation, shared and unclustered cells, bad codes and a clear
  task automatic test_special_cells();
    send_req(mk_read(REQ_RD_CL, 10'd5));
    send_req(mk_cell(18'h3FFFF, 32'h8000_0000, 32'd1, 1'b1, 1'b0, 10'd5, 10'd0));
    send_req(mk_cell(18'd0, 32'h0, 32'h0, 1'b1, 1'b0, 10'd5, 10'd0));
    send_req(mk_cell(18'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 10'd5, 10'd9));
    send_req(mk_cell(18'd8, -32'sd3, 32'd1, 1'b1, 1'b0, 10'h3FF, 10'd9));
    send_req(mk_cell(18'd9, 32'd3, 32'd1, 1'b1, 1'b0, 10'h3FF, 10'd9));
    send_req(mk_cell(18'd2, 32'd20, 32'd10, 1'b1, 1'b1, 10'd6, 10'd6));
    send_req(mk_cell(18'd3, 32'd1, 32'd1, 1'b1, 1'b1, 10'd6, 10'h3FF));
    send_req(mk_cell(18'd4, 32'd5, 32'd0, 1'b0, 1'b1, 10'd6, 10'd6));
    send_req(mk_cell(18'd5, 32'd2, 32'd2, 1'b1, 1'b0, 10'd6, 10'd0));
    send_req(mk_read(REQ_BAD_FIRST, '0));
    send_req(mk_read(REQ_BAD_LAST, '0));
    read_everything(10'd5);
    read_everything(10'd6);
    send_req(mk_read(REQ_RD_CL, 10'h3FF));
    send_req(mk_read(REQ_CLR, '0));
    read_everything(10'd6);
  endtask

  task automatic test_threshold_extremes();
    write_thresholds(SNR_SAT, SNR_SAT, SNR_SAT);
    send_req(mk_cell(18'd1, 32'd1, 32'd0, 1'b1, 1'b0, 10'd1, 10'd0));
    send_req(mk_cell(18'd2, 32'd9, 32'd1, 1'b1, 1'b0, 10'd1, 10'd0));
    read_everything(10'd1);
    write_thresholds('0, '0, '0);
    send_req(mk_cell(18'd3, 32'd0, 32'd5, 1'b1, 1'b0, 10'd1, 10'd0));
    send_req(mk_cell(18'd4, 32'd1, 32'd5, 1'b1, 1'b0, 10'd1, 10'd0));
    read_everything(10'd1);
  endtask

  task automatic test_random_mix(int n, int snd_pct, int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int i = 0; i < n; i++) send_req(random_req());
  endtask

  // receiver stalls long, the sender keeps pushing until full backs up
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_start = 1;
    for (int i = 0; i < 60; i++) send_req(mk_read(REQ_RD_ALL, '0));
  endtask

  // the sender waits for all reports before going on
  task automatic test_sender_pause();
    for (int i = 0; i < 20; i++) send_req(random_req());
    drain();
    for (int i = 0; i < 30; i++) send_req(random_req());
  endtask

  // receiver with idling and a counted long hold
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // each output transfer against the oldest expected report
  always @(posedge clk) begin
    count_rpt_t x;
    logic [CNT_W-1:0] got [5];
    if (rst_n && pop && !empty) begin
      got[0] = out_total_count;
      got[1] = out_seed_count;
      got[2] = out_grow_count;
      got[3] = out_term_count;
      got[4] = out_below_count;
      if (pending_reports.size() == 0) begin
        $display("%0t: report expected none got total %0d", $time, out_total_count);
        errors++;
      end else begin
        x = pending_reports.pop_front();
        for (int k = 0; k < 5; k++)
          if (got[k] !== x.cnt[k]) begin
            $display("%0t: count slot %0d expected %0d got %0d", $time, k, x.cnt[k], got[k]);
            errors++;
          end
        if (out_shared_count !== x.shr) begin
          $display("%0t: shared_count expected %0d got %0d", $time, x.shr, out_shared_count);
          errors++;
        end
        if (out_max_snr !== x.max_snr) begin
          $display("%0t: max_snr expected %h got %h", $time, x.max_snr, out_max_snr);
          errors++;
        end
        if (out_max_energy !== x.max_energy) begin
          $display("%0t: max_energy expected %h got %h", $time, x.max_energy, out_max_energy);
          errors++;
        end
        if (out_max_cell !== x.max_cell) begin
          $display("%0t: max_cell expected %0d got %0d", $time, x.max_cell, out_max_cell);
          errors++;
        end
        if (out_has_max !== x.has_max) begin
          $display("%0t: has_max expected %b got %b", $time, x.has_max, out_has_max);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_counts();
    for (int c = 0; c < NUM_CLUSTERS; c++) cl_best_ok[c] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cells();
    test_threshold_extremes();
    write_thresholds(32'h0004_0000, 32'h0002_0000, 32'h0000_8000);
    test_random_mix(330, 15, 74);
    write_thresholds($urandom, $urandom, $urandom);
    test_random_mix(330, 74, 15);
    write_thresholds(32'h0008_0000, 32'h0001_8000, 32'h0000_4000);
    test_random_mix(330, 0, 0);
    test_output_stall();
    test_sender_pause();
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
